>>> rtl/lif_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_pkg
// Shared types for the length-field codec pipeline: formula groups and the
// payload structs that travel between pipeline stages.
// ----------------------------------------------------------------------------
package lif_pkg;

  // Decode formula groups, chosen from the file type code
  typedef enum logic [2:0] {
    DC_NONE = 3'd0,  // unknown type
    DC_SECT = 3'd1,  // sectors times 256
    DC_NIB  = 3'd2,  // nibble count, rounded up to bytes
    DC_E0D0 = 3'd3,  // upper half word times 8
    DC_E0F0 = 3'd4,  // records times record length
    DC_REC8 = 3'd5,  // register count times 8 plus 1
    DC_E080 = 3'd6   // register count plus 1
  } dec_class_t;

  // Encode formula groups
  typedef enum logic [2:0] {
    EC_NONE = 3'd0,
    EC_NIB  = 3'd1,
    EC_E0D0 = 3'd2,
    EC_REC8 = 3'd3,
    EC_E080 = 3'd4
  } enc_class_t;

  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  // Stage 1: request with its formula groups resolved
  typedef struct packed {
    logic        opcode;
    dec_class_t  dcls;
    enc_class_t  ecls;
    logic [31:0] sector_count;
    logic [31:0] general_purpose;
    logic [31:0] byte_count;
  } s1_t;

  // Stage 2: multiplier operands, non-multiply length, encode results
  typedef struct packed {
    logic        known;
    logic        use_mul;
    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic [39:0] alt_len;
    logic [31:0] gp_out;
    logic [24:0] sectors;
  } s2_t;

  // Stage 3: product registered
  typedef struct packed {
    logic        known;
    logic        use_mul;
    logic [31:0] product;
    logic [39:0] alt_len;
    logic [31:0] gp_out;
    logic [24:0] sectors;
  } s3_t;

endpackage

>>> rtl/lif_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_classify
// First stage: map the file type code to its decode and encode formula group
// and register the request.
// ----------------------------------------------------------------------------
module lif_classify (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic [15:0]        type_code,
  input  logic [31:0]        sector_count,
  input  logic [31:0]        general_purpose,
  input  logic [31:0]        byte_count,
  output logic               out_valid,
  input  logic               out_ready,
  output lif_pkg::s1_t       out_data
);

  localparam logic [15:0] FT_LIF_DATA = 16'h0001;
  localparam logic [15:0] FT_BIN_RAW  = 16'h00ff;
  localparam logic [15:0] FT_DAT_REG  = 16'he020;
  localparam logic [15:0] FT_DAT_R30  = 16'he030;
  localparam logic [15:0] FT_DAT_R40  = 16'he040;
  localparam logic [15:0] FT_DAT_R50  = 16'he050;
  localparam logic [15:0] FT_DAT_R60  = 16'he060;
  localparam logic [15:0] FT_DAT_R70  = 16'he070;
  localparam logic [15:0] FT_KEYS     = 16'he080;
  localparam logic [15:0] FT_TEXT     = 16'he0d0;
  localparam logic [15:0] FT_TEXT_ALT = 16'he0d1;
  localparam logic [15:0] FT_RECS     = 16'he0f0;
  localparam logic [15:0] FT_RECS_ALT = 16'he0f1;
  localparam logic [15:0] FT_NIB_LO   = 16'he204;
  localparam logic [15:0] FT_NIB_HI   = 16'he20d;
  localparam logic [15:0] FT_NIB_EN1  = 16'he208;
  localparam logic [15:0] FT_NIB_EN2  = 16'he20c;
  localparam logic [15:0] FT_NIB2_LO  = 16'he214;
  localparam logic [15:0] FT_NIB2_HI  = 16'he217;
  localparam logic [15:0] FT_SECT_LO  = 16'he218;
  localparam logic [15:0] FT_SECT_HI  = 16'he21b;
  localparam logic [15:0] FT_LEX      = 16'he21c;
  localparam logic [15:0] FT_NIB_E222 = 16'he222;
  localparam logic [15:0] FT_NIB_E224 = 16'he224;
  localparam logic [15:0] FT_NIB_E22E = 16'he22e;

  lif_pkg::dec_class_t dcls;
  lif_pkg::enc_class_t ecls;

  always_comb begin
    if (type_code == FT_LIF_DATA || type_code == FT_TEXT_ALT ||
        (type_code >= FT_SECT_LO && type_code <= FT_SECT_HI)) begin
      dcls = lif_pkg::DC_SECT;
    end else if (type_code == FT_BIN_RAW ||
                 (type_code >= FT_NIB_LO && type_code <= FT_NIB_HI) ||
                 (type_code >= FT_NIB2_LO && type_code <= FT_NIB2_HI) ||
                 type_code == FT_LEX || type_code == FT_NIB_E222 ||
                 type_code == FT_NIB_E224 || type_code == FT_NIB_E22E) begin
      dcls = lif_pkg::DC_NIB;
    end else if (type_code == FT_TEXT) begin
      dcls = lif_pkg::DC_E0D0;
    end else if (type_code == FT_RECS || type_code == FT_RECS_ALT) begin
      dcls = lif_pkg::DC_E0F0;
    end else if (type_code == FT_DAT_REG || type_code == FT_DAT_R30 ||
                 type_code == FT_DAT_R40 || type_code == FT_DAT_R50 ||
                 type_code == FT_DAT_R60 || type_code == FT_DAT_R70) begin
      dcls = lif_pkg::DC_REC8;
    end else if (type_code == FT_KEYS) begin
      dcls = lif_pkg::DC_E080;
    end else begin
      dcls = lif_pkg::DC_NONE;
    end
  end

  always_comb begin
    if (type_code == FT_NIB_LO || type_code == FT_NIB_EN1 ||
        type_code == FT_NIB_EN2 || type_code == FT_NIB2_LO ||
        type_code == FT_LEX) begin
      ecls = lif_pkg::EC_NIB;
    end else if (type_code == FT_TEXT) begin
      ecls = lif_pkg::EC_E0D0;
    end else if (type_code == FT_DAT_R40 || type_code == FT_DAT_R50 ||
                 type_code == FT_DAT_R60 || type_code == FT_DAT_R70) begin
      ecls = lif_pkg::EC_REC8;
    end else if (type_code == FT_KEYS) begin
      ecls = lif_pkg::EC_E080;
    end else begin
      ecls = lif_pkg::EC_NONE;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.opcode          <= opcode;
      out_data.dcls            <= dcls;
      out_data.ecls            <= ecls;
      out_data.sector_count    <= sector_count;
      out_data.general_purpose <= general_purpose;
      out_data.byte_count      <= byte_count;
    end
  end

endmodule

>>> rtl/lif_operand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_operand
// Second stage: split the general-purpose bytes into multiplier operands or a
// direct length, and finish the encode word and sector count.
// ----------------------------------------------------------------------------
module lif_operand (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  lif_pkg::s1_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output lif_pkg::s2_t out_data
);

  lif_pkg::s2_t next;
  logic [7:0]   b0, b1, b2, b3;
  logic [24:0]  nib_sum;
  logic [31:0]  bc, bc_m1, bc_x2;

  assign b0 = in_data.general_purpose[31:24];
  assign b1 = in_data.general_purpose[23:16];
  assign b2 = in_data.general_purpose[15:8];
  assign b3 = in_data.general_purpose[7:0];
  assign bc = in_data.byte_count;
  assign bc_m1 = bc - 32'd1;
  assign bc_x2 = {bc[30:0], 1'b0};
  // nibble count is stored low byte first
  assign nib_sum = {1'b0, b2, b1, b0} + 25'd1;

  always_comb begin
    next = '0;
    if (in_data.opcode == lif_pkg::OP_DECODE) begin
      next.known = (in_data.dcls != lif_pkg::DC_NONE);
      case (in_data.dcls)
        lif_pkg::DC_SECT: next.alt_len = {in_data.sector_count, 8'h00};
        lif_pkg::DC_NIB:  next.alt_len = {16'h0000, nib_sum[24:1]};
        lif_pkg::DC_E0D0: next.alt_len = {21'h0, in_data.general_purpose[31:16], 3'b000};
        lif_pkg::DC_E0F0: begin
          next.use_mul = 1'b1;
          next.mul_a   = {b1, b0};
          next.mul_b   = {b3, b2};
        end
        lif_pkg::DC_REC8: next.alt_len = {21'h0, b0, b1, 3'b001};
        lif_pkg::DC_E080: next.alt_len = 40'({b0, b1}) + 40'd1;
        default:          next.alt_len = '0;
      endcase
    end else begin
      case (in_data.ecls)
        lif_pkg::EC_NIB:  next.gp_out = {bc_x2[7:0], bc_x2[15:8], bc_x2[23:16], bc_x2[31:24]};
        lif_pkg::EC_E0D0: next.gp_out = {bc[21:3], 13'h0000};
        lif_pkg::EC_REC8: next.gp_out = {bc_m1[18:3], 16'h0000};
        lif_pkg::EC_E080: next.gp_out = {bc_m1[15:0], 16'h0000};
        default:          next.gp_out = '0;
      endcase
      // round up to whole sectors; zero bytes give zero sectors
      next.sectors = (bc == 32'd0) ? 25'd0 : ({1'b0, bc_m1[31:8]} + 25'd1);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= next;
    end
  end

endmodule

>>> rtl/lif_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_multiply
// Third stage: 16 by 16 record-size product, other fields carried along.
// ----------------------------------------------------------------------------
module lif_multiply (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  lif_pkg::s2_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output lif_pkg::s3_t out_data
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.known   <= in_data.known;
      out_data.use_mul <= in_data.use_mul;
      out_data.product <= 32'(in_data.mul_a) * 32'(in_data.mul_b);
      out_data.alt_len <= in_data.alt_len;
      out_data.gp_out  <= in_data.gp_out;
      out_data.sectors <= in_data.sectors;
    end
  end

endmodule

>>> rtl/lif_length_field_codec_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_length_field_codec_top
// Length-field codec for a directory entry: decodes the used byte length from
// the sector count and general-purpose bytes, or encodes the general-purpose
// word and sector count from a byte count, as picked by the file type.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata fields (low bit up)                      | tuser
//  --------+-----+------------------------------------------------+-----------
//  s_*     | in  | type_code, sector_count, general_purpose,      | opcode
//          |     | byte_count                                     |
//  m_*     | out | used_length, general_purpose_out, sectors_out  | type_known
//
//  One request per cycle sustained while m_tready stays high; a result is
//  registered in turn by the classify, operand, multiply and output
//  register stages before it is offered.
//  The 16 by 16 record-size multiply sets the depth of the middle stages.
//  rst is synchronous and empties every stage; payload registers keep junk.
//  Each stage holds while the one after it is full and stalled; an empty
//  stage fills even when the output is stalled, so bubbles squeeze out.
// ----------------------------------------------------------------------------
module lif_length_field_codec_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [15:0] type_code, [47:16] sector_count, [79:48] general_purpose,
  // [111:80] byte_count
  input  logic [111:0] s_tdata,
  // [0] opcode
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [39:0] used_length, [71:40] general_purpose_out, [96:72] sectors_out,
  // [103:97] zero
  output logic [103:0] m_tdata,
  // [0] type_known
  output logic         m_tuser
);

  logic         v1, v2, v3;
  logic         r2, r3, r4;
  lif_pkg::s1_t d1;
  lif_pkg::s2_t d2;
  lif_pkg::s3_t d3;
  logic [39:0]  used_length;
  logic         type_known;
  logic [31:0]  gp_out;
  logic [24:0]  sectors_out;

  // Classify the file type and register the request
  lif_classify u_classify (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .opcode          (s_tuser),
    .type_code       (s_tdata[15:0]),
    .sector_count    (s_tdata[47:16]),
    .general_purpose (s_tdata[79:48]),
    .byte_count      (s_tdata[111:80]),
    .out_valid       (v1),
    .out_ready       (r2),
    .out_data        (d1)
  );

  // Form operands, direct lengths and the encode results
  lif_operand u_operand (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (r2),
    .in_data   (d1),
    .out_valid (v2),
    .out_ready (r3),
    .out_data  (d2)
  );

  // Record-size product
  lif_multiply u_multiply (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (r3),
    .in_data   (d2),
    .out_valid (v3),
    .out_ready (r4),
    .out_data  (d3)
  );

  // Output register: pick the product or the direct length
  assign r4 = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (r4) begin
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      used_length <= d3.use_mul ? {8'h00, d3.product} : d3.alt_len;
      type_known  <= d3.known;
      gp_out      <= d3.gp_out;
      sectors_out <= d3.sectors;
    end
  end

  assign m_tdata = {7'h00, sectors_out, gp_out, used_length};
  assign m_tuser = type_known;

  // A decoded result never carries encode fields
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[96:40] == 57'h0)
    else $error("known decode result with nonzero encode fields");

  // An encode result with sectors never carries a decoded length
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[96:72] != 25'h0 |-> m_tdata[39:0] == 40'h0 && !m_tuser)
    else $error("encode result with decoded length");

  // With the output empty every stage can advance, so input is open
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");

  // A taken result leaves a slot, so the multiply stage result moves out
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && v3 |=> m_tvalid)
    else $error("pending result lost at output");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the length-field codec. Requests go in over the
// s_* stream from a queue of pending requests. Each accepted request is run
// through a behavioral predictor of the decode and encode formulas. Each
// result taken from the m_* stream is compared field by field with the
// oldest prediction. A directed set covers every formula group, the field
// extremes, unknown types and the wrapping subtractions. Random phases then
// vary how often the sender idles and the receiver stalls, and one long
// receiver hold-off backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module tb;

  // File type codes that select a formula
  localparam logic [15:0] FT_0001 = 16'h0001;
  localparam logic [15:0] FT_00FF = 16'h00ff;
  localparam logic [15:0] FT_E020 = 16'he020;
  localparam logic [15:0] FT_E030 = 16'he030;
  localparam logic [15:0] FT_E040 = 16'he040;
  localparam logic [15:0] FT_E050 = 16'he050;
  localparam logic [15:0] FT_E060 = 16'he060;
  localparam logic [15:0] FT_E070 = 16'he070;
  localparam logic [15:0] FT_E080 = 16'he080;
  localparam logic [15:0] FT_E0D0 = 16'he0d0;
  localparam logic [15:0] FT_E0D1 = 16'he0d1;
  localparam logic [15:0] FT_E0F0 = 16'he0f0;
  localparam logic [15:0] FT_E0F1 = 16'he0f1;
  localparam logic [15:0] FT_E204 = 16'he204;
  localparam logic [15:0] FT_E205 = 16'he205;
  localparam logic [15:0] FT_E206 = 16'he206;
  localparam logic [15:0] FT_E207 = 16'he207;
  localparam logic [15:0] FT_E208 = 16'he208;
  localparam logic [15:0] FT_E209 = 16'he209;
  localparam logic [15:0] FT_E20A = 16'he20a;
  localparam logic [15:0] FT_E20B = 16'he20b;
  localparam logic [15:0] FT_E20C = 16'he20c;
  localparam logic [15:0] FT_E20D = 16'he20d;
  localparam logic [15:0] FT_E214 = 16'he214;
  localparam logic [15:0] FT_E215 = 16'he215;
  localparam logic [15:0] FT_E216 = 16'he216;
  localparam logic [15:0] FT_E217 = 16'he217;
  localparam logic [15:0] FT_E218 = 16'he218;
  localparam logic [15:0] FT_E219 = 16'he219;
  localparam logic [15:0] FT_E21A = 16'he21a;
  localparam logic [15:0] FT_E21B = 16'he21b;
  localparam logic [15:0] FT_E21C = 16'he21c;
  localparam logic [15:0] FT_E222 = 16'he222;
  localparam logic [15:0] FT_E224 = 16'he224;
  localparam logic [15:0] FT_E22E = 16'he22e;
  // Codes outside every formula group
  localparam logic [15:0] FT_UNLISTED_LO = 16'h0000;
  localparam logic [15:0] FT_UNLISTED_HI = 16'hffff;

  // All listed codes, packed so random requests can pick one by index
  localparam int N_LISTED = 35;
  localparam logic [N_LISTED*16-1:0] LISTED_TYPES = {
    FT_0001, FT_00FF, FT_E020, FT_E030, FT_E040, FT_E050, FT_E060, FT_E070,
    FT_E080, FT_E0D0, FT_E0D1, FT_E0F0, FT_E0F1, FT_E204, FT_E205, FT_E206,
    FT_E207, FT_E208, FT_E209, FT_E20A, FT_E20B, FT_E20C, FT_E20D, FT_E214,
    FT_E215, FT_E216, FT_E217, FT_E218, FT_E219, FT_E21A, FT_E21B, FT_E21C,
    FT_E222, FT_E224, FT_E22E};

  localparam int RANDOM_PER_PHASE = 357;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 20;

  typedef struct packed {
    logic        opcode;
    logic [15:0] type_code;
    logic [31:0] sector_count;
    logic [31:0] general_purpose;
    logic [31:0] byte_count;
  } hdr_req_t;

  typedef struct packed {
    logic [39:0] used_length;
    logic        type_known;
    logic [31:0] gp_out;
    logic [24:0] sectors;
  } len_fields_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         m_tuser;

  hdr_req_t    pending_reqs[$];
  len_fields_t expected_fields[$];
  hdr_req_t    offered_req;
  bit          offered_taken = 1'b0;
  int          n_queued = 0;
  int          n_taken = 0;
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_start = 1'b0;
  int          hold_left = 0;

  lif_length_field_codec_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Predict the result fields of one request
  function automatic len_fields_t length_field_of(hdr_req_t r);
    len_fields_t res;
    logic [7:0]  b0, b1, b2, b3;
    logic [24:0] nibbles;
    logic [31:0] bc_less1, doubled;
    b0 = r.general_purpose[31:24];
    b1 = r.general_purpose[23:16];
    b2 = r.general_purpose[15:8];
    b3 = r.general_purpose[7:0];
    res = '0;
    if (r.opcode == lif_pkg::OP_DECODE) begin
      res.type_known = 1'b1;
      nibbles = {1'b0, b2, b1, b0} + 25'd1;
      case (r.type_code)
        FT_0001, FT_E0D1, FT_E218, FT_E219, FT_E21A, FT_E21B: begin
          res.used_length = {r.sector_count, 8'h00};
        end
        FT_00FF, FT_E204, FT_E205, FT_E206, FT_E207, FT_E208, FT_E209,
        FT_E20A, FT_E20B, FT_E20C, FT_E20D, FT_E214, FT_E215, FT_E216,
        FT_E217, FT_E21C, FT_E222, FT_E224, FT_E22E: begin
          // nibble count rounded up to whole bytes
          res.used_length = 40'(nibbles >> 1);
        end
        FT_E0D0: begin
          res.used_length = 40'({r.general_purpose[31:16], 3'b000});
        end
        FT_E0F0, FT_E0F1: begin
          res.used_length = 40'({b1, b0}) * 40'({b3, b2});
        end
        FT_E020, FT_E030, FT_E040, FT_E050, FT_E060, FT_E070: begin
          res.used_length = 40'({b0, b1, 3'b000}) + 40'd1;
        end
        FT_E080: begin
          res.used_length = 40'({b0, b1}) + 40'd1;
        end
        default: begin
          res.type_known = 1'b0;
        end
      endcase
    end else begin
      bc_less1 = r.byte_count - 32'd1;
      doubled  = r.byte_count << 1;
      case (r.type_code)
        FT_E204, FT_E208, FT_E20C, FT_E214, FT_E21C: begin
          // doubled count, stored low byte first
          res.gp_out = {doubled[7:0], doubled[15:8], doubled[23:16], doubled[31:24]};
        end
        FT_E0D0: begin
          res.gp_out = (r.byte_count >> 3) << 13;
        end
        FT_E040, FT_E050, FT_E060, FT_E070: begin
          res.gp_out = (bc_less1 >> 3) << 16;
        end
        FT_E080: begin
          res.gp_out = bc_less1 << 16;
        end
        default: begin
          res.gp_out = '0;
        end
      endcase
      res.sectors = (r.byte_count == 32'd0) ? 25'd0 : 25'(bc_less1 >> 8) + 25'd1;
    end
    return res;
  endfunction

  task automatic queue_req(input logic op, input logic [15:0] ft,
                           input logic [31:0] sc, input logic [31:0] gp,
                           input logic [31:0] bc);
    hdr_req_t r;
    r.opcode = op;
    r.type_code = ft;
    r.sector_count = sc;
    r.general_purpose = gp;
    r.byte_count = bc;
    pending_reqs.push_back(r);
    n_queued++;
  endtask

  // Mix extremes and small counts into otherwise uniform words
  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'($urandom_range(600));
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_req();
    logic [15:0] ft;
    int          idx;
    idx = $urandom_range(N_LISTED - 1);
    // mostly listed codes so every formula sees traffic; the rest is noise
    if ($urandom_range(99) < 80) ft = LISTED_TYPES[idx*16 +: 16];
    else ft = 16'($urandom);
    queue_req(1'($urandom_range(1)), ft, rand_word(), rand_word(), rand_word());
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Block until every queued request is taken and every result is back
  task automatic wait_drained();
    while (n_taken != n_queued || expected_fields.size() != 0) @(posedge clk);
  endtask

  // Request driver: hold the offer until taken, then advance or idle
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || offered_taken)) begin
      offered_taken = 1'b0;
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        offered_req = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {offered_req.byte_count, offered_req.general_purpose,
                     offered_req.sector_count, offered_req.type_code};
        s_tuser  <= offered_req.opcode;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off when asked for
  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on each taken request, check each taken result
  always @(posedge clk) begin
    len_fields_t want;
    len_fields_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_fields.push_back(length_field_of(offered_req));
        offered_taken = 1'b1;
        n_taken++;
      end
      if (m_tvalid && m_tready) begin
        got.used_length = m_tdata[39:0];
        got.gp_out      = m_tdata[71:40];
        got.sectors     = m_tdata[96:72];
        got.type_known  = m_tuser;
        if (expected_fields.size() == 0) begin
          $error("result with no request outstanding: m_tdata 0x%0h", m_tdata);
          mismatches++;
        end else begin
          want = expected_fields.pop_front();
          check_field("used_length", 64'(want.used_length), 64'(got.used_length));
          check_field("type_known", 64'(want.type_known), 64'(got.type_known));
          check_field("general_purpose_out", 64'(want.gp_out), 64'(got.gp_out));
          check_field("sectors_out", 64'(want.sectors), 64'(got.sectors));
        end
      end
    end
  end

  // Stimulus and run control
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every formula group with its field extremes
    queue_req(lif_pkg::OP_DECODE, FT_0001, 32'hffff_ffff, $urandom, $urandom);
    queue_req(lif_pkg::OP_DECODE, FT_E0D1, 32'h0000_0000, 32'hffff_ffff, $urandom);
    queue_req(lif_pkg::OP_DECODE, FT_00FF, $urandom, 32'hffff_ffff, 32'hffff_ffff);
    queue_req(lif_pkg::OP_DECODE, FT_E20D, 32'hffff_ffff, 32'h0000_0000, $urandom);
    // single nibble rounds up to one byte
    queue_req(lif_pkg::OP_DECODE, FT_E22E, $urandom, 32'h0100_00ff, $urandom);
    queue_req(lif_pkg::OP_DECODE, FT_E0D0, $urandom, 32'hffff_0000, $urandom);
    // largest record product
    queue_req(lif_pkg::OP_DECODE, FT_E0F0, $urandom, 32'hffff_ffff, $urandom);
    queue_req(lif_pkg::OP_DECODE, FT_E0F1, $urandom, 32'h0000_0000, $urandom);
    queue_req(lif_pkg::OP_DECODE, FT_E020, $urandom, 32'hffff_0000, $urandom);
    queue_req(lif_pkg::OP_DECODE, FT_E070, $urandom, 32'h0000_0000, $urandom);
    queue_req(lif_pkg::OP_DECODE, FT_E080, $urandom, 32'hffff_ffff, $urandom);
    // unknown types decode to zero with the flag clear
    queue_req(lif_pkg::OP_DECODE, FT_UNLISTED_LO,
              32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    queue_req(lif_pkg::OP_DECODE, FT_UNLISTED_HI,
              32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    queue_req(lif_pkg::OP_ENCODE, FT_E204,
              32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    queue_req(lif_pkg::OP_ENCODE, FT_E21C, $urandom, $urandom, 32'h0000_0000);
    queue_req(lif_pkg::OP_ENCODE, FT_E0D0, $urandom, $urandom, 32'hffff_ffff);
    // zero byte count wraps the subtraction
    queue_req(lif_pkg::OP_ENCODE, FT_E040, $urandom, $urandom, 32'h0000_0000);
    queue_req(lif_pkg::OP_ENCODE, FT_E070, $urandom, $urandom, 32'h0000_0001);
    queue_req(lif_pkg::OP_ENCODE, FT_E080, $urandom, $urandom, 32'h0000_0000);
    queue_req(lif_pkg::OP_ENCODE, FT_E080, $urandom, $urandom, 32'hffff_ffff);
    // unlisted encode types give a zero word but still count sectors
    queue_req(lif_pkg::OP_ENCODE, FT_0001, $urandom, $urandom, 32'h0000_0100);
    queue_req(lif_pkg::OP_ENCODE, FT_00FF, $urandom, $urandom, 32'h0000_0101);
    queue_req(lif_pkg::OP_ENCODE, FT_UNLISTED_HI, $urandom, $urandom, 32'h0000_0001);
    wait_drained();

    // Random phase with no idling; stall the receiver long enough that the
    // pipeline fills and drops s_tready while requests keep coming
    repeat (RANDOM_PER_PHASE) queue_random_req();
    hold_start = 1'b1;
    wait_drained();

    // Sender idles most cycles
    send_idle_pct = 68;
    recv_stall_pct = 0;
    repeat (RANDOM_PER_PHASE) queue_random_req();
    wait_drained();

    // Receiver stalls most cycles
    send_idle_pct = 0;
    recv_stall_pct = 68;
    repeat (RANDOM_PER_PHASE) queue_random_req();
    wait_drained();

    // Both sides idle about a third of the time
    send_idle_pct = 35;
    recv_stall_pct = 35;
    repeat (RANDOM_PER_PHASE) queue_random_req();
    wait_drained();

    // Let any stray result surface past the pipeline depth
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
